@@ sv/qstd_pkg.sv @@
// Shared types, constants and tables for the smallest-three quaternion decoder.
// No dependencies; every other file uses it by scoped names.
package qstd_pkg;

   // Packed-mode magnitude scale: |q| = (m*K + 511*512) / (511*1024)
   localparam int unsigned PACK_K    = 11863283;
   localparam int unsigned PACK_BIAS = 511 * 512;

   // 1.0 squared in Q4.28
   localparam logic [29:0] ONE_SQ = 30'h1000_0000;

   // Square root: 15 two-bit digits, three per pipeline stage
   localparam int unsigned SQRT_ITERS     = 15;
   localparam int unsigned SQRT_PER_STAGE = 3;
   localparam int unsigned SQRT_STAGES    = SQRT_ITERS / SQRT_PER_STAGE;

   // Component indexes
   localparam logic [1:0] IDX_W = 2'd0;
   localparam logic [1:0] IDX_X = 2'd1;
   localparam logic [1:0] IDX_Y = 2'd2;
   localparam logic [1:0] IDX_Z = 2'd3;

   // rotation_format codes
   localparam logic FMT_BYTES  = 1'b0;
   localparam logic FMT_PACKED = 1'b1;

   typedef logic signed [15:0] comp_type;
   typedef logic [28:0]        rem_type;
   typedef logic [14:0]        root_type;

   // Stored components in group order (group 0 holds bits 9:0), largest index, last flag
   typedef struct packed {
      comp_type [2:0] slot;
      logic [1:0]     big;
      logic           last;
   } side_type;

   typedef struct packed {
      logic [29:0] rest;
      logic [29:0] root;
   } sqrt_state_type;

   typedef comp_type byte_lut_type [256];

   // Byte b maps to b/127.5 - 1 in Q2.14, rounded to nearest
   function automatic byte_lut_type build_byte_lut();
      byte_lut_type lut;
      int b;
      int d;
      int m;
      int q;
      for (b = 0; b < 256; b++) begin
         d = 2 * b - 255;
         m = (d < 0) ? -d : d;
         q = (m * 32768 + 255) / 510;
         lut[b] = comp_type'((d < 0) ? -q : q);
      end
      return lut;
   endfunction

   localparam byte_lut_type BYTE_LUT = build_byte_lut();

   // One restoring square-root digit; j counts digits from the top
   function automatic sqrt_state_type sqrt_step(input sqrt_state_type st, input int unsigned j);
      sqrt_state_type nx;
      logic [29:0]    bit_w;
      logic [29:0]    trial;
      bit_w = 30'd1 << (28 - 2 * j);
      trial = st.root + bit_w;
      if (st.rest >= trial) begin
         nx.rest = st.rest - trial;
         nx.root = (st.root >> 1) + bit_w;
      end else begin
         nx.rest = st.rest;
         nx.root = st.root >> 1;
      end
      return nx;
   endfunction

endpackage

@@ sv/quaternion_smallest_three_decode.sv @@
// Top level of the smallest-three quaternion decoder: format register, unpack,
// sum of squares, square root, component placement and the output register.
// Depends on qstd_pkg, qstd_unpack, qstd_sumsq and qstd_isqrt.
//
// Decodes one compressed unit quaternion per beat into four signed Q2.14
// components (16384 = 1.0). With rotation_format = 1 (reset value) the word is
// the packed smallest-three form: bits 31:30 name the largest component and
// three 10-bit sign/magnitude groups from bit 0 up fill the other components
// from z downward, skipping the largest; the largest is rebuilt as the rounded
// square root of 1 - sum of squares (0 if that goes negative). With
// rotation_format = 0 bytes 7:0, 15:8, 23:16 are x, y, z (b/127.5 - 1) and w is
// rebuilt; bits 31:24 are ignored. The last flag rides along unchanged.
// The datapath is fully pipelined: a new beat is taken every cycle unless a
// stalled output has filled the pipeline, and each item passes through 3 unpack
// stages, 3 sum-of-squares stages, 5 square-root stages of three digits each,
// one rounding stage and one output register. Each stage advances
// on its own, so bubbles collapse and the input keeps flowing while a result
// waits at the output. Write csr_write_data only while the block is drained.
module quaternion_smallest_three_decode (
   input  logic        clock,
   input  logic        reset,

   input  logic        csr_write_enable,
   input  logic        csr_write_data,

   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_packed_rotation,
   input  logic        req_is_last_in,

   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_quat_w,
   output logic signed [15:0] rsp_quat_x,
   output logic signed [15:0] rsp_quat_y,
   output logic signed [15:0] rsp_quat_z,
   output logic        rsp_is_last_out
);

   logic rotation_format_ff;

   logic               unp_valid;
   logic               unp_ready;
   qstd_pkg::side_type unp_side;

   logic               sum_valid;
   logic               sum_ready;
   qstd_pkg::rem_type  sum_rem;
   qstd_pkg::side_type sum_side;

   logic               rt_valid;
   logic               rt_ready;
   qstd_pkg::root_type rt_root;
   qstd_pkg::side_type rt_side;

   logic               out_adv;
   logic               rsp_valid_ff;
   qstd_pkg::comp_type quat_w_ff, quat_x_ff, quat_y_ff, quat_z_ff;
   qstd_pkg::comp_type quat_w_in, quat_x_in, quat_y_in, quat_z_in;
   logic               last_ff;

   // format register: reset to the packed form
   always_ff @(posedge clock) begin
      if (reset) begin
         rotation_format_ff <= qstd_pkg::FMT_PACKED;
      end else if (csr_write_enable) begin
         rotation_format_ff <= csr_write_data;
      end
   end

   qstd_unpack u_unpack (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_packed_rotation),
      .in_format (rotation_format_ff),
      .in_last   (req_is_last_in),
      .out_valid (unp_valid),
      .out_ready (unp_ready),
      .out_side  (unp_side)
   );

   qstd_sumsq u_sumsq (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (unp_valid),
      .in_ready  (unp_ready),
      .in_side   (unp_side),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_rem   (sum_rem),
      .out_side  (sum_side)
   );

   qstd_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_rem    (sum_rem),
      .in_side   (sum_side),
      .out_valid (rt_valid),
      .out_ready (rt_ready),
      .out_root  (rt_root),
      .out_side  (rt_side)
   );

   // the output register takes a beat whenever it is empty or being drained
   assign out_adv  = !rsp_valid_ff || rsp_ready;
   assign rt_ready = out_adv;

   // drop the rebuilt root into the largest slot; group 0 always lands on the
   // highest index left, group 2 on the lowest
   always_comb begin
      qstd_pkg::comp_type root_c;
      root_c = qstd_pkg::comp_type'({1'b0, rt_root});
      case (rt_side.big)
         qstd_pkg::IDX_W: begin
            quat_w_in = root_c;
            quat_x_in = rt_side.slot[2];
            quat_y_in = rt_side.slot[1];
            quat_z_in = rt_side.slot[0];
         end
         qstd_pkg::IDX_X: begin
            quat_w_in = rt_side.slot[2];
            quat_x_in = root_c;
            quat_y_in = rt_side.slot[1];
            quat_z_in = rt_side.slot[0];
         end
         qstd_pkg::IDX_Y: begin
            quat_w_in = rt_side.slot[2];
            quat_x_in = rt_side.slot[1];
            quat_y_in = root_c;
            quat_z_in = rt_side.slot[0];
         end
         default: begin
            // largest is z
            quat_w_in = rt_side.slot[2];
            quat_x_in = rt_side.slot[1];
            quat_y_in = rt_side.slot[0];
            quat_z_in = root_c;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_adv) begin
         rsp_valid_ff <= rt_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_adv) begin
         quat_w_ff <= quat_w_in;
         quat_x_ff <= quat_x_in;
         quat_y_ff <= quat_y_in;
         quat_z_ff <= quat_z_in;
         last_ff   <= rt_side.last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_quat_w      = quat_w_ff;
   assign rsp_quat_x      = quat_x_ff;
   assign rsp_quat_y      = quat_y_ff;
   assign rsp_quat_z      = quat_z_ff;
   assign rsp_is_last_out = last_ff;

endmodule

@@ sv/qstd_unpack.sv @@
// Three-stage unpack of the stored components into signed Q2.14 values.
// Depends on qstd_pkg (byte table, scale constants, side_type).
module qstd_unpack (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic [31:0]        in_word,
   input  logic               in_format,
   input  logic               in_last,
   output logic               out_valid,
   input  logic               out_ready,
   output qstd_pkg::side_type out_side
);

   logic u1_adv;
   logic u2_adv;
   logic u3_adv;

   // stage 1: scaled magnitude before the divide by 511, byte table lookup
   logic                        u1_valid_ff;
   logic [2:0][22:0]            u1_x_ff;
   logic [2:0][22:0]            u1_x_in;
   logic [2:0]                  u1_sign_ff;
   qstd_pkg::comp_type [2:0]    u1_byte_ff;
   qstd_pkg::comp_type [2:0]    u1_byte_in;
   logic                        u1_format_ff;
   logic [1:0]                  u1_big_ff;
   logic [1:0]                  u1_big_in;
   logic                        u1_last_ff;

   // stage 2: quotient estimate
   logic                        u2_valid_ff;
   logic [2:0][22:0]            u2_x_ff;
   logic [2:0][14:0]            u2_qe_ff;
   logic [2:0][14:0]            u2_qe_in;
   logic [2:0]                  u2_sign_ff;
   qstd_pkg::comp_type [2:0]    u2_byte_ff;
   logic                        u2_format_ff;
   logic [1:0]                  u2_big_ff;
   logic                        u2_last_ff;

   // stage 3: corrected, signed components
   logic                        u3_valid_ff;
   qstd_pkg::side_type          u3_side_ff;
   qstd_pkg::side_type          u3_side_in;

   assign u3_adv   = !u3_valid_ff || out_ready;
   assign u2_adv   = !u2_valid_ff || u3_adv;
   assign u1_adv   = !u1_valid_ff || u2_adv;
   assign in_ready = u1_adv;

   always_comb begin
      logic [8:0]  mag;
      logic [32:0] prod;
      for (int i = 0; i < 3; i++) begin
         mag           = in_word[10*i +: 9];
         prod          = 33'(mag) * 33'(qstd_pkg::PACK_K) + 33'(qstd_pkg::PACK_BIAS);
         u1_x_in[i]    = prod[32:10];
         u1_byte_in[i] = qstd_pkg::BYTE_LUT[in_word[8*(2-i) +: 8]];
      end
      // byte mode always rebuilds w
      u1_big_in = (in_format == qstd_pkg::FMT_PACKED) ? in_word[31:30] : qstd_pkg::IDX_W;
   end

   // x/511 from the series x/512 + x/512^2 + x/512^3; low by at most one
   always_comb begin
      logic [23:0] t;
      for (int i = 0; i < 3; i++) begin
         t           = 24'(u1_x_ff[i]) + 24'(u1_x_ff[i] >> 9) + 24'(u1_x_ff[i] >> 18);
         u2_qe_in[i] = t[23:9];
      end
   end

   always_comb begin
      logic [23:0]        r;
      logic [14:0]        mag;
      qstd_pkg::comp_type val;
      u3_side_in = '0;
      for (int i = 0; i < 3; i++) begin
         r   = 24'(u2_x_ff[i]) - ({u2_qe_ff[i], 9'b0} - 24'(u2_qe_ff[i]));
         mag = (r[9:0] >= 10'd511) ? u2_qe_ff[i] + 15'd1 : u2_qe_ff[i];
         val = u2_sign_ff[i] ? -qstd_pkg::comp_type'({1'b0, mag})
                             :  qstd_pkg::comp_type'({1'b0, mag});
         u3_side_in.slot[i] = (u2_format_ff == qstd_pkg::FMT_PACKED) ? val : u2_byte_ff[i];
      end
      u3_side_in.big  = u2_big_ff;
      u3_side_in.last = u2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         u1_valid_ff <= 1'b0;
         u2_valid_ff <= 1'b0;
         u3_valid_ff <= 1'b0;
      end else begin
         if (u1_adv) u1_valid_ff <= in_valid;
         if (u2_adv) u2_valid_ff <= u1_valid_ff;
         if (u3_adv) u3_valid_ff <= u2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (u1_adv) begin
         u1_x_ff      <= u1_x_in;
         u1_sign_ff   <= {in_word[29], in_word[19], in_word[9]};
         u1_byte_ff   <= u1_byte_in;
         u1_format_ff <= in_format;
         u1_big_ff    <= u1_big_in;
         u1_last_ff   <= in_last;
      end
      if (u2_adv) begin
         u2_x_ff      <= u1_x_ff;
         u2_qe_ff     <= u2_qe_in;
         u2_sign_ff   <= u1_sign_ff;
         u2_byte_ff   <= u1_byte_ff;
         u2_format_ff <= u1_format_ff;
         u2_big_ff    <= u1_big_ff;
         u2_last_ff   <= u1_last_ff;
      end
      if (u3_adv) begin
         u3_side_ff <= u3_side_in;
      end
   end

   assign out_valid = u3_valid_ff;
   assign out_side  = u3_side_ff;

endmodule

@@ sv/qstd_sumsq.sv @@
// Three-stage sum of squares of the stored components and the remainder 1 - S.
// Depends on qstd_pkg (side_type, rem_type, ONE_SQ).
module qstd_sumsq (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qstd_pkg::side_type in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output qstd_pkg::rem_type  out_rem,
   output qstd_pkg::side_type out_side
);

   logic s1_adv;
   logic s2_adv;
   logic s3_adv;

   logic               s1_valid_ff;
   logic [2:0][28:0]   s1_sq_ff;
   logic [2:0][28:0]   s1_sq_in;
   qstd_pkg::side_type s1_side_ff;

   logic               s2_valid_ff;
   logic [29:0]        s2_sum_ff;
   logic [29:0]        s2_sum_in;
   qstd_pkg::side_type s2_side_ff;

   logic               s3_valid_ff;
   qstd_pkg::rem_type  s3_rem_ff;
   qstd_pkg::rem_type  s3_rem_in;
   qstd_pkg::side_type s3_side_ff;

   assign s3_adv   = !s3_valid_ff || out_ready;
   assign s2_adv   = !s2_valid_ff || s3_adv;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // |q| <= 1.0, so each square fits 29 bits
   always_comb begin
      logic signed [31:0] p;
      for (int i = 0; i < 3; i++) begin
         p           = in_side.slot[i] * in_side.slot[i];
         s1_sq_in[i] = p[28:0];
      end
   end

   assign s2_sum_in = 30'(s1_sq_ff[0]) + 30'(s1_sq_ff[1]) + 30'(s1_sq_ff[2]);

   // clamp at zero when the stored part already exceeds one
   assign s3_rem_in = (s2_sum_ff > qstd_pkg::ONE_SQ) ? '0
                                                     : 29'(qstd_pkg::ONE_SQ - s2_sum_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         if (s1_adv) s1_valid_ff <= in_valid;
         if (s2_adv) s2_valid_ff <= s1_valid_ff;
         if (s3_adv) s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_sq_ff   <= s1_sq_in;
         s1_side_ff <= in_side;
      end
      if (s2_adv) begin
         s2_sum_ff  <= s2_sum_in;
         s2_side_ff <= s1_side_ff;
      end
      if (s3_adv) begin
         s3_rem_ff  <= s3_rem_in;
         s3_side_ff <= s2_side_ff;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_rem   = s3_rem_ff;
   assign out_side  = s3_side_ff;

endmodule

@@ sv/qstd_isqrt.sv @@
// Pipelined rounded integer square root, three digits per stage plus a rounding stage.
// Depends on qstd_pkg (sqrt_step, stage counts, side_type).
module qstd_isqrt (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  qstd_pkg::rem_type  in_rem,
   input  qstd_pkg::side_type in_side,
   output logic               out_valid,
   input  logic               out_ready,
   output qstd_pkg::root_type out_root,
   output qstd_pkg::side_type out_side
);

   localparam int unsigned NS = qstd_pkg::SQRT_STAGES + 1;

   logic [NS:0]              adv;
   logic [NS-1:0]            stg_valid_ff;
   logic [NS-1:0]            prev_valid;
   qstd_pkg::side_type       side_ff [NS];
   qstd_pkg::side_type       prev_side [NS];
   qstd_pkg::sqrt_state_type st_ff [qstd_pkg::SQRT_STAGES];
   qstd_pkg::sqrt_state_type st_in [qstd_pkg::SQRT_STAGES];
   qstd_pkg::sqrt_state_type prev_st [qstd_pkg::SQRT_STAGES];
   qstd_pkg::root_type       root_ff;
   qstd_pkg::root_type       root_in;

   assign adv[NS]  = out_ready;
   assign in_ready = adv[0];

   for (genvar g = 0; g < NS; g++) begin : g_ctl
      assign adv[g] = !stg_valid_ff[g] || adv[g+1];
      if (g == 0) begin : g_first
         assign prev_valid[g] = in_valid;
         assign prev_side[g]  = in_side;
      end else begin : g_next
         assign prev_valid[g] = stg_valid_ff[g-1];
         assign prev_side[g]  = side_ff[g-1];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            stg_valid_ff[g] <= 1'b0;
         end else if (adv[g]) begin
            stg_valid_ff[g] <= prev_valid[g];
         end
      end

      always_ff @(posedge clock) begin
         if (adv[g]) begin
            side_ff[g] <= prev_side[g];
         end
      end
   end

   for (genvar g = 0; g < qstd_pkg::SQRT_STAGES; g++) begin : g_digit
      if (g == 0) begin : g_first
         assign prev_st[g] = '{rest: 30'(in_rem), root: 30'd0};
      end else begin : g_next
         assign prev_st[g] = st_ff[g-1];
      end

      always_comb begin
         qstd_pkg::sqrt_state_type st;
         st = prev_st[g];
         for (int i = 0; i < qstd_pkg::SQRT_PER_STAGE; i++) begin
            st = qstd_pkg::sqrt_step(st, g * qstd_pkg::SQRT_PER_STAGE + i);
         end
         st_in[g] = st;
      end

      always_ff @(posedge clock) begin
         if (adv[g]) begin
            st_ff[g] <= st_in[g];
         end
      end
   end

   // round to nearest: bump when the leftover exceeds the root
   always_comb begin
      qstd_pkg::sqrt_state_type fin;
      logic [15:0]              bumped;
      fin     = st_ff[qstd_pkg::SQRT_STAGES-1];
      bumped  = 16'(fin.root) + 16'd1;
      root_in = (fin.rest > fin.root) ? bumped[14:0] : fin.root[14:0];
   end

   always_ff @(posedge clock) begin
      if (adv[NS-1]) begin
         root_ff <= root_in;
      end
   end

   assign out_valid = stg_valid_ff[NS-1];
   assign out_root  = root_ff;
   assign out_side  = side_ff[NS-1];

endmodule
